// ----- hw/rtl/cm3_pkg.sv -----
package cm3_pkg;

    localparam int COORD_W     = 16;
    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int SUM1_W      = 22;
    localparam int SUMP_W      = 38;
    localparam int CROSS_W     = 2 * SUM1_W;
    localparam int DIFF_W      = 46;
    localparam int FRAC_W      = 8;
    localparam int MAG_W       = DIFF_W + FRAC_W;
    localparam int OUT_W       = 41;
    localparam int N_FIELDS    = 9;
    localparam int OUT_TDATA_W = ((N_FIELDS * OUT_W + 7) / 8) * 8;
    localparam int N_ENT       = 6;
    localparam int ENT_W       = 3;

    // distinct matrix entries: xx, xy, xz, yy, yz, zz
    localparam logic [ENT_W-1:0] ENT_XX = 3'd0;
    localparam logic [ENT_W-1:0] ENT_XY = 3'd1;
    localparam logic [ENT_W-1:0] ENT_XZ = 3'd2;
    localparam logic [ENT_W-1:0] ENT_YY = 3'd3;
    localparam logic [ENT_W-1:0] ENT_YZ = 3'd4;
    localparam logic [ENT_W-1:0] ENT_ZZ = 3'd5;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic             take;
        logic             clear;
        logic             mul;
        logic             start;
        logic             store;
        logic             push;
        logic [ENT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

    function automatic logic [1:0] ent_a(input logic [ENT_W-1:0] e);
        logic [1:0] a;
        case (e)
            ENT_XX, ENT_XY, ENT_XZ: a = AX_X;
            ENT_YY, ENT_YZ:         a = AX_Y;
            ENT_ZZ:                 a = AX_Z;
            default:                a = AX_X;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] ent_b(input logic [ENT_W-1:0] e);
        logic [1:0] b;
        case (e)
            ENT_XX:         b = AX_X;
            ENT_XY, ENT_YY: b = AX_Y;
            ENT_XZ, ENT_YZ: b = AX_Z;
            ENT_ZZ:         b = AX_Z;
            default:        b = AX_X;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/cm3_div.sv -----
module cm3_div #(
    parameter int DEN   = 100,
    parameter int DEN_W = 7,
    parameter int MAG_W = 54
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quo,
    output logic             o_rem_nz
);

    // each dividend digit: multiply by the reciprocal, then
    // take the remainder back out
    localparam int DIG_W = 18;
    localparam int N_DIG = (MAG_W + DIG_W - 1) / DIG_W;
    localparam int NUM_W = N_DIG * DIG_W;
    localparam int V_W   = DEN_W + DIG_W;
    localparam int M_W   = V_W + 1;
    localparam int SHIFT = V_W + $clog2(DEN);
    localparam int CNT_W = $clog2(N_DIG + 1);
    localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DEN) - longint'(1))
                             / longint'(DEN);

    logic                 r_busy;
    logic                 r_phase;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [V_W+M_W-1:0]   r_prod;

    logic [M_W-1:0]   c_recip;
    logic [V_W-1:0]   w_v;
    logic [DIG_W-1:0] w_q;
    logic [V_W-1:0]   w_qd;
    logic [V_W-1:0]   w_r;

    assign c_recip = M_W'(RECIP);
    assign w_v     = {r_rem, r_quo[NUM_W-1 -: DIG_W]};
    assign w_q     = r_prod[SHIFT +: DIG_W];
    assign w_qd    = V_W'(w_q) * V_W'(DEN);
    assign w_r     = w_v - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= CNT_W'(N_DIG);
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // dividend digits leave at the top while quotient digits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= NUM_W'(i_mag);
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_phase) begin
                r_quo <= {r_quo[NUM_W-DIG_W-1:0], w_q};
                r_rem <= w_r[DEN_W-1:0];
            end else begin
                r_prod <= w_v * c_recip;
            end
        end
    end

    assign o_done   = r_busy && r_phase && (r_cnt == CNT_W'(1));
    assign o_quo    = r_quo[MAG_W-1:0];
    assign o_rem_nz = |r_rem;

endmodule

// ----- hw/rtl/cm3_dpath.sv -----
module cm3_dpath #(
    parameter int POINTS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cm3_pkg::t_cmd                   i_cmd,
    output cm3_pkg::t_sts                   o_sts,
    input  logic [cm3_pkg::IN_TDATA_W-1:0]  i_pt_data,
    output logic [cm3_pkg::OUT_TDATA_W-1:0] o_out_data
);

    localparam int NW    = $clog2(POINTS + 1);
    localparam int DEN   = POINTS * POINTS;
    localparam int DEN_W = $clog2(DEN + 1);
    localparam int PAD_W = cm3_pkg::OUT_TDATA_W - cm3_pkg::N_FIELDS * cm3_pkg::OUT_W;

    logic signed [NW:0] c_n;
    assign c_n = (NW+1)'(POINTS);

    logic signed [cm3_pkg::COORD_W-1:0]   w_c   [3];
    logic                                 r_pv;
    logic signed [cm3_pkg::COORD_W-1:0]   r_c   [3];
    logic signed [2*cm3_pkg::COORD_W-1:0] r_p   [cm3_pkg::N_ENT];
    logic signed [cm3_pkg::SUM1_W-1:0]    r_sf  [3];
    logic signed [cm3_pkg::SUMP_W-1:0]    r_sp  [cm3_pkg::N_ENT];
    logic signed [cm3_pkg::CROSS_W-1:0]   r_cross;
    logic signed [cm3_pkg::DIFF_W-1:0]    r_scaled;
    logic                                 r_neg;
    logic signed [cm3_pkg::OUT_W-1:0]     r_res [cm3_pkg::N_ENT];
    logic [cm3_pkg::OUT_TDATA_W-1:0]      r_out;

    logic signed [cm3_pkg::DIFF_W-1:0] w_diff;
    logic signed [cm3_pkg::MAG_W-1:0]  w_num;
    logic [cm3_pkg::MAG_W-1:0]         w_mag;
    logic [cm3_pkg::MAG_W-1:0]         w_quo;
    logic [cm3_pkg::MAG_W-1:0]         w_q;
    logic                              w_rem_nz;
    logic                              w_done;

    assign w_c[0] = i_pt_data[cm3_pkg::COORD_W-1:0];
    assign w_c[1] = i_pt_data[2*cm3_pkg::COORD_W-1:cm3_pkg::COORD_W];
    assign w_c[2] = i_pt_data[3*cm3_pkg::COORD_W-1:2*cm3_pkg::COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.take;
        end
    end

    // multiply stage: one product per distinct entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= w_c[i];
            end
            for (int j = 0; j < cm3_pkg::N_ENT; j++) begin
                r_p[j] <= w_c[cm3_pkg::ent_a(cm3_pkg::ENT_W'(j))]
                        * w_c[cm3_pkg::ent_b(cm3_pkg::ENT_W'(j))];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 3; i++) begin
                r_sf[i] <= '0;
            end
            for (int j = 0; j < cm3_pkg::N_ENT; j++) begin
                r_sp[j] <= '0;
            end
        end else if (r_pv) begin
            for (int i = 0; i < 3; i++) begin
                r_sf[i] <= r_sf[i] + cm3_pkg::SUM1_W'(r_c[i]);
            end
            for (int j = 0; j < cm3_pkg::N_ENT; j++) begin
                r_sp[j] <= r_sp[j] + cm3_pkg::SUMP_W'(r_p[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_cross  <= cm3_pkg::CROSS_W'(r_sf[cm3_pkg::ent_a(i_cmd.idx)])
                      * cm3_pkg::CROSS_W'(r_sf[cm3_pkg::ent_b(i_cmd.idx)]);
            r_scaled <= cm3_pkg::DIFF_W'(r_sp[i_cmd.idx]) * cm3_pkg::DIFF_W'(c_n);
        end
    end

    assign w_diff = r_scaled - cm3_pkg::DIFF_W'(r_cross);
    assign w_num  = {w_diff, {cm3_pkg::FRAC_W{1'b0}}};
    assign w_mag  = w_num[cm3_pkg::MAG_W-1] ? -w_num : w_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_neg <= w_diff[cm3_pkg::DIFF_W-1];
        end
    end

    cm3_div #(
        .DEN   (DEN),
        .DEN_W (DEN_W),
        .MAG_W (cm3_pkg::MAG_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_mag    (w_mag),
        .o_done   (w_done),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    // round toward minus infinity for negative numerators
    assign w_q = r_neg ? -(w_quo + cm3_pkg::MAG_W'(w_rem_nz)) : w_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_res[i_cmd.idx] <= w_q[cm3_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= {{PAD_W{1'b0}},
                      r_res[cm3_pkg::ENT_ZZ], r_res[cm3_pkg::ENT_YZ], r_res[cm3_pkg::ENT_XZ],
                      r_res[cm3_pkg::ENT_YZ], r_res[cm3_pkg::ENT_YY], r_res[cm3_pkg::ENT_XY],
                      r_res[cm3_pkg::ENT_XZ], r_res[cm3_pkg::ENT_XY], r_res[cm3_pkg::ENT_XX]};
        end
    end

    assign o_sts.div_done = w_done;
    assign o_out_data     = r_out;

endmodule

// ----- hw/rtl/cm3_ctrl.sv -----
module cm3_ctrl #(
    parameter int POINTS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output cm3_pkg::t_cmd o_cmd,
    input  cm3_pkg::t_sts i_sts
);

    localparam int CNT_W = $clog2(POINTS);

    typedef enum logic [6:0] {
        S_ACC   = 7'b0000001,
        S_FLUSH = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [cm3_pkg::ENT_W-1:0] r_idx, n_idx;
    logic                      r_ovld, n_ovld;
    logic                      w_free;

    assign w_free = !r_ovld || i_m_tready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ovld  = r_ovld && !i_m_tready;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_ACC: begin
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (r_cnt == CNT_W'(POINTS - 1)) begin
                        n_cnt   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                n_idx   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_idx == cm3_pkg::ENT_ZZ) begin
                    n_state = S_PUSH;
                end else begin
                    n_idx   = r_idx + cm3_pkg::ENT_W'(1);
                    n_state = S_MUL;
                end
            end
            S_PUSH: begin
                // hold until the output register is free
                if (w_free) begin
                    o_cmd.push  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_ovld      = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ovld  <= n_ovld;
        end
    end

    assign o_s_tready = (r_state == S_ACC);
    assign o_m_tvalid = r_ovld;

endmodule

// ----- hw/rtl/covariance_matrix_3d_core.sv -----
// Population covariance of batches of POINTS signed 3-D points.
// Input stream: one point per request, tdata = {z, y, x}, 16 bits each.
// Output stream: one request per batch carrying the nine 41-bit matrix
// entries (8 fractional bits), cov_xx in the lowest bits up to cov_zz.
// Points are taken one per cycle while a batch is collected: each is
// multiplied into six products and added to the running sums in the cycle after.
// After the last point of a batch, input tready drops while the six distinct
// entries are formed one after another on a shared divider by N*N that
// takes 18-bit digits by reciprocal multiplication, each digit in a multiply
// step and then a remainder step; per entry the control passes the states
// MUL, LOAD, DIV and STORE, then pushes the matrix out after the last one.
// The result sits in an output register; the next batch is accepted while it
// waits. If the receiver still stalls when the following result is ready,
// the block holds that result and keeps input tready low until it can load.
// Reset (synchronous, active low) clears the sums and point count, drops
// output tvalid and leaves the block ready for the first point.
module covariance_matrix_3d_core #(
    parameter int POINTS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // x_coord [15:0], y_coord [31:16], z_coord [47:32]
    input  logic [cm3_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // cov_xx, cov_xy, cov_xz, cov_yx, cov_yy, cov_yz, cov_zx, cov_zy, cov_zz,
    // 41 bits each from bit 0 up, zero fill in [375:369]
    output logic [cm3_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    cm3_pkg::t_cmd w_cmd;
    cm3_pkg::t_sts w_sts;

    cm3_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    cm3_dpath #(
        .POINTS (POINTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_pt_data  (i_s_tdata),
        .o_out_data (o_m_tdata)
    );

endmodule

// ----- hw/rtl/cm3_chk.sv -----
module cm3_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [cm3_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [cm3_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int USED_W = cm3_pkg::N_FIELDS * cm3_pkg::OUT_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output data changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[cm3_pkg::OUT_TDATA_W-1:USED_W] == '0)
        else $error("output fill bits not zero");

endmodule

bind covariance_matrix_3d_core cm3_chk u_cm3_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/covariance_matrix_3d_core_test.sv -----
module covariance_matrix_3d_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cm3_pkg::*;

    localparam int BATCH     = 10;
    localparam int RX_HOLD   = 1500;
    localparam int DRAIN_LAT = 400;
    localparam int MAT_W     = N_FIELDS * OUT_W;

    // kinds of point groups in the random part
    localparam int STYLE_FULL    = 0;
    localparam int STYLE_SMALL   = 1;
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_CONST   = 3;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        bit                 drain;
        bit                 stall_rx;
    } t_point;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // x_coord [15:0], y_coord [31:16], z_coord [47:32]
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // cov_xx .. cov_zz, 41 bits each from bit 0 up, zero fill on top
    logic [OUT_TDATA_W-1:0] m_tdata;

    t_point             point_queue[$];
    logic [MAT_W-1:0]   cov_expected[$];
    t_point             cur_point;
    bit                 cur_stall_rx = 0;

    // running sums of the current batch
    int                 batch_count;
    longint             sum_lin[3];
    longint             sum_prod[N_ENT];

    bit                 point_taken  = 0;
    bit                 result_taken = 0;
    bit                 rx_hold_req  = 0;
    int                 rx_hold_left = 0;
    int                 tx_gap = 0, tx_calm = 0;
    int                 rx_wait = 0, rx_calm = 0;
    int                 mismatches = 0;
    int                 points_sent = 0;
    int                 matrices_seen = 0;

    covariance_matrix_3d_core #(.POINTS(BATCH)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic [ENT_W-1:0] ent_of(input int a, input int b);
        int lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == AX_X) begin
            if (hi == AX_X) return ENT_XX;
            if (hi == AX_Y) return ENT_XY;
            return ENT_XZ;
        end
        if (lo == AX_Y) begin
            if (hi == AX_Y) return ENT_YY;
            return ENT_YZ;
        end
        return ENT_ZZ;
    endfunction

    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic string field_name(input int f);
        case (f)
            0:       return "cov_xx";
            1:       return "cov_xy";
            2:       return "cov_xz";
            3:       return "cov_yx";
            4:       return "cov_yy";
            5:       return "cov_yz";
            6:       return "cov_zx";
            7:       return "cov_zy";
            default: return "cov_zz";
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    // add one point to the sums; close the batch into an expected matrix
    task automatic accumulate_point(input logic [COORD_W-1:0] xr, yr, zr);
        longint           c[3];
        longint           num, val;
        logic [MAT_W-1:0] mat;
        int               r, k;
        c[AX_X] = longint'($signed(xr));
        c[AX_Y] = longint'($signed(yr));
        c[AX_Z] = longint'($signed(zr));
        for (r = 0; r < 3; r++) sum_lin[r] += c[r];
        sum_prod[ENT_XX] += c[AX_X] * c[AX_X];
        sum_prod[ENT_XY] += c[AX_X] * c[AX_Y];
        sum_prod[ENT_XZ] += c[AX_X] * c[AX_Z];
        sum_prod[ENT_YY] += c[AX_Y] * c[AX_Y];
        sum_prod[ENT_YZ] += c[AX_Y] * c[AX_Z];
        sum_prod[ENT_ZZ] += c[AX_Z] * c[AX_Z];
        batch_count++;
        if (batch_count == BATCH) begin
            mat = '0;
            for (r = 0; r < 3; r++) begin
                for (k = 0; k < 3; k++) begin
                    num = longint'(BATCH) * sum_prod[ent_of(r, k)] - sum_lin[r] * sum_lin[k];
                    val = floor_div(num * 256, longint'(BATCH) * BATCH);
                    mat[(r * 3 + k) * OUT_W +: OUT_W] = val[OUT_W-1:0];
                end
            end
            cov_expected.push_back(mat);
            batch_count = 0;
            for (r = 0; r < 3; r++) sum_lin[r] = 0;
            for (r = 0; r < N_ENT; r++) sum_prod[r] = 0;
        end
    endtask

    task automatic check_matrix(input logic [OUT_TDATA_W-1:0] got);
        logic [MAT_W-1:0] want;
        int               f;
        if (cov_expected.size() == 0) begin
            log_mismatch("result with no batch pending");
            return;
        end
        want = cov_expected.pop_front();
        for (f = 0; f < N_FIELDS; f++) begin
            if (got[f * OUT_W +: OUT_W] !== want[f * OUT_W +: OUT_W])
                log_mismatch($sformatf("matrix %0d %s got %0d want %0d", matrices_seen,
                    field_name(f), $signed(got[f * OUT_W +: OUT_W]),
                    $signed(want[f * OUT_W +: OUT_W])));
        end
        if (got[OUT_TDATA_W-1:MAT_W] !== '0)
            log_mismatch($sformatf("matrix %0d nonzero fill bits", matrices_seen));
        matrices_seen++;
    endtask

    // sample both handshakes at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                accumulate_point(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W],
                                 s_tdata[3*COORD_W-1:2*COORD_W]);
                points_sent++;
                point_taken = 1;
                if (cur_stall_rx) rx_hold_req = 1;
            end
            if (m_tvalid && m_tready) begin
                check_matrix(m_tdata);
                result_taken = 1;
            end
        end
    end

    // point driver
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || point_taken) begin
            point_taken = 0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (point_queue.size() != 0 &&
                         !(point_queue[0].drain && cov_expected.size() != 0)) begin
                cur_point = point_queue.pop_front();
                cur_stall_rx = cur_point.stall_rx;
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_point.z, cur_point.y, cur_point.x};
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else begin
                    tx_gap = idle_len();
                    if ($urandom_range(0, 249) == 0) tx_calm = $urandom_range(100, 400);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_req = 0;
                rx_hold_left = RX_HOLD;
            end
            if (result_taken) begin
                result_taken = 0;
                if (rx_calm > 0) begin
                    rx_calm--;
                    rx_wait = 0;
                end else begin
                    rx_wait = idle_len() * 4;
                    if ($urandom_range(0, 29) == 0) rx_calm = $urandom_range(5, 15);
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_point(input logic [COORD_W-1:0] xv, yv, zv,
                               input bit drain, input bit stall_rx);
        t_point p;
        p.x = xv;
        p.y = yv;
        p.z = zv;
        p.drain = drain;
        p.stall_rx = stall_rx;
        point_queue.push_back(p);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int style,
                                                       input logic [COORD_W-1:0] anchor);
        int v;
        case (style)
            STYLE_SMALL: v = int'($urandom_range(0, 10)) - 5;
            STYLE_EXTREME: begin
                if ($urandom_range(0, 1) == 1) v = 32767 - int'($urandom_range(0, 15));
                else v = -32768 + int'($urandom_range(0, 15));
            end
            STYLE_CONST: v = int'(anchor);
            default:     v = int'($urandom_range(0, 65535));
        endcase
        return v[COORD_W-1:0];
    endfunction

    initial begin
        int                 i, style;
        logic [COORD_W-1:0] ax, ay, az;
        batch_count = 0;
        for (i = 0; i < 3; i++) sum_lin[i] = 0;
        for (i = 0; i < N_ENT; i++) sum_prod[i] = 0;

        // widest spread, with y opposite in sign to x and z
        for (i = 0; i < BATCH; i++) begin
            if (i % 2 == 0) queue_point(16'h7fff, 16'h8000, 16'h7fff, 0, 0);
            else queue_point(16'h8000, 16'h7fff, 16'h8000, 0, 0);
        end
        // all points equal at the negative extreme: zero matrix
        for (i = 0; i < BATCH; i++) queue_point(16'h8000, 16'h8000, 16'h8000, 0, 0);
        // start of a batch that the random part completes
        queue_point(16'h0000, 16'h0000, 16'h0000, 0, 0);
        queue_point(16'hffff, 16'h0001, 16'h0000, 0, 0);
        queue_point(16'h0001, 16'hffff, 16'hffff, 0, 0);
        queue_point(16'h7fff, 16'h0000, 16'h8000, 0, 0);
        queue_point(16'h0000, 16'h8000, 16'h7fff, 0, 0);

        style = STYLE_FULL;
        ax = '0; ay = '0; az = '0;
        for (i = 0; i < 1375; i++) begin
            if (i % BATCH == 0) begin
                case ($urandom_range(0, 9))
                    6, 7:    style = STYLE_SMALL;
                    8:       style = STYLE_EXTREME;
                    9:       style = STYLE_CONST;
                    default: style = STYLE_FULL;
                endcase
                ax = COORD_W'($urandom_range(0, 65535));
                ay = COORD_W'($urandom_range(0, 65535));
                az = COORD_W'($urandom_range(0, 65535));
            end
            queue_point(pick_coord(style, ax), pick_coord(style, ay), pick_coord(style, az),
                        i == 505 || i == 1005, i == 295);
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (point_queue.size() != 0 || s_tvalid) @(posedge clk);
        while (cov_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_LAT) @(posedge clk);

        $display("tb: %0d points sent in batches of %0d, %0d matrices checked, %0d mismatches",
                 points_sent, BATCH, matrices_seen, mismatches);
        $display("tb: covered extremes, constant and small-valued batches, long output stall");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- covariance_matrix_3d_core.f -----
hw/rtl/cm3_pkg.sv
hw/rtl/cm3_div.sv
hw/rtl/cm3_dpath.sv
hw/rtl/cm3_ctrl.sv
hw/rtl/covariance_matrix_3d_core.sv
hw/rtl/cm3_chk.sv
tb/sv/covariance_matrix_3d_core_test.sv
